// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication every clock edge outside reset.
`define NPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check a next-cycle implication outside reset.
`define NPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/npm_pkg.sv -----
// ----------------------------------------------------------------------------
// npm_pkg
// Shared types and constants of the neighbor proximity monitor.
// ----------------------------------------------------------------------------
package npm_pkg;
    localparam int unsigned POS_W   = 24;
    localparam int unsigned DIST_W  = 25;
    localparam int unsigned SQ_W    = 50;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned IN_W    = 64;
    localparam int unsigned OUT_W   = 40;
    localparam logic CMD_UPDATE     = 1'b0;
    localparam logic CMD_TICK       = 1'b1;
    localparam logic KIND_ACK       = 1'b0;
    localparam logic KIND_TICK      = 1'b1;
endpackage

// ----- rtl/core/npm_sqrt.sv -----
// ----------------------------------------------------------------------------
// npm_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module npm_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [npm_pkg::SQ_W-1:0]   i_rad,
    output logic                       o_done,
    output logic [npm_pkg::DIST_W-1:0] o_root
);
    import npm_pkg::*;

    localparam int unsigned STEPS = DIST_W;

    logic [SQ_W+1:0]   r_rem,  n_rem;
    logic [DIST_W-1:0] r_root, n_root;
    logic [SQ_W-1:0]   r_rad,  n_rad;
    logic [4:0]        r_cnt,  n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SQ_W+1:0]   trial;
    logic [SQ_W+1:0]   shifted;

    always_comb begin
        n_rem  = r_rem;
        n_root = r_root;
        n_rad  = r_rad;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        shifted = {r_rem[SQ_W-1:0], r_rad[SQ_W-1 -: 2]};
        trial   = {{(SQ_W+2-DIST_W-2){1'b0}}, r_root, 2'b01};
        if (i_start) begin
            n_rem  = '0;
            n_root = '0;
            n_rad  = i_rad;
            n_cnt  = 5'(STEPS - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // restoring step: bring in two bits, try root*4+1
            n_rad = {r_rad[SQ_W-3:0], 2'b00};
            if (shifted >= trial) begin
                n_rem  = shifted - trial;
                n_root = {r_root[DIST_W-2:0], 1'b1};
            end else begin
                n_rem  = shifted;
                n_root = {r_root[DIST_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
            n_cnt = r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rad  <= n_rad;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- rtl/core/npm_div.sv -----
// ----------------------------------------------------------------------------
// npm_div
// Restoring divider for the mean distance, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module npm_div #(
    parameter int unsigned NUM_W = 36,
    parameter int unsigned DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DEN_W:0]   shl;

    always_comb begin
        n_quo = r_quo; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        shl = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        if (i_start) begin
            n_quo = i_num; n_rem = '0; n_den = i_den;
            n_cnt = CW'(NUM_W - 1); n_busy = 1'b1;
        end else if (r_busy) begin
            if (shl >= {1'b0, r_den}) begin
                n_rem = shl - {1'b0, r_den};
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = shl;
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_quo <= n_quo; r_rem <= n_rem; r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ----- rtl/core/neighbor_proximity_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// neighbor_proximity_monitor_unit
// Neighbor table with position updates and a periodic proximity report.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tuser=command, tdata=id,x,y
// m_axis    out  tvalid/tready        tuser=report_kind, tdata=report
// cfg       in   i_cfg_we             risk_distance
//
// An update searches the table entry by entry, each in a read state (address)
// and then a compare state (registered read data), up to a hit or, for a new id,
// past all stored entries; the memory read latency sets the pace.
// A tick walks each stored entry through read, compare, square, root start and
// the wait on the shared square root, then runs the divide; an empty table
// skips both and goes straight to the report.
// Reset clears control only; the fill count marks valid slots, no clear pass.
// A stalled result holds in the output register; no request is taken until
// it leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module neighbor_proximity_monitor_unit #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned ID_BITS       = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [npm_pkg::IN_W-1:0]   s_axis_tdata,  // neighbor_id[15:0], pos_x, pos_y
    input  logic                       s_axis_tuser,  // command
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [npm_pkg::OUT_W-1:0]  m_axis_tdata,  // accepted, count[7], mean[25], risky
    output logic                       m_axis_tuser,  // report_kind
    input  logic                       i_cfg_we,
    input  logic [npm_pkg::POS_W-1:0]  i_cfg_wdata
);
    import npm_pkg::*;

    localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
    localparam int unsigned TW  = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned SUM_W = DIST_W + TW;
    localparam int unsigned MW  = ID_BITS + 2 * POS_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam logic [2:0] ST_RUN  = 3'd7;

    // table memory: {id, x, y}
    logic [MW-1:0] mem [TABLE_ENTRIES];
    logic [MW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa, r_ra;

    logic [2:0]         r_state;
    logic [TW-1:0]      r_total;
    logic [TW-1:0]      r_idx;
    logic               r_cmd;
    logic [ID_BITS-1:0] r_id;
    logic signed [POS_W-1:0] r_px, r_py;
    logic [POS_W-1:0]   r_risk;
    logic [SUM_W-1:0]   r_sum;
    logic               r_flag;
    logic [POS_W:0]     r_dx, r_dy;
    logic [SQ_W-1:0]    r_sq;
    logic               r_ov;
    logic [OUT_W-1:0]   r_odata;
    logic               r_ouser;

    logic sq_start, sq_done, dv_start, dv_done;
    logic [DIST_W-1:0] root;
    logic [SUM_W-1:0]  quo;

    logic [ID_BITS-1:0] m_id;
    logic signed [POS_W-1:0] m_x, m_y;
    logic signed [POS_W:0] ddx, ddy;
    logic [SQ_W-1:0] sqx, sqy;

    assign m_id = r_rdata[2*POS_W +: ID_BITS];
    assign m_x  = r_rdata[POS_W +: POS_W];
    assign m_y  = r_rdata[0 +: POS_W];
    assign ddx  = (POS_W+1)'(r_px) - (POS_W+1)'(m_x);
    assign ddy  = (POS_W+1)'(r_py) - (POS_W+1)'(m_y);
    assign sqx  = SQ_W'(r_dx) * SQ_W'(r_dx);
    assign sqy  = SQ_W'(r_dy) * SQ_W'(r_dy);

    assign s_axis_tready = (r_state == ST_IDLE) && !m_axis_tvalid;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    assign mem_we = (r_state == ST_CHK) && (r_cmd == CMD_UPDATE)
                    && (r_idx == r_total) && (r_total != TW'(TABLE_ENTRIES));
    assign mem_wa = r_total[AW-1:0];
    assign sq_start = (r_state == ST_MUL);
    // start the divide as the walk leaves its last compare; the sum is final
    assign dv_start = (r_state == ST_CHK) && (r_cmd == CMD_TICK)
                      && (r_idx == r_total) && (r_total != '0);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHK && r_cmd == CMD_UPDATE && r_idx < r_total && m_id == r_id)
            mem[r_ra] <= {r_id, r_px, r_py};
        else if (mem_we)
            mem[mem_wa] <= {r_id, r_px, r_py};
        r_rdata <= mem[r_ra];
    end

    npm_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_rad(r_sq), .o_done(sq_done), .o_root(root)
    );

    npm_div #(.NUM_W(SUM_W), .DEN_W(TW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start),
        .i_num(r_sum), .i_den(r_total), .o_done(dv_done), .o_quo(quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            r_ov    <= 1'b0;
            r_risk  <= POS_W'(160);
        end else begin
            if (i_cfg_we) r_risk <= i_cfg_wdata;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd  <= s_axis_tuser;
                        r_id   <= ID_BITS'(s_axis_tdata[15:0]);
                        r_px   <= s_axis_tdata[16 +: POS_W];
                        r_py   <= s_axis_tdata[40 +: POS_W];
                        r_idx  <= '0;
                        r_ra   <= '0;
                        r_sum  <= '0;
                        r_flag <= 1'b0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: r_state <= ST_CHK; // read data lands next cycle
                ST_CHK: begin
                    if (r_cmd == CMD_UPDATE) begin
                        if (r_idx == r_total) begin
                            r_odata <= OUT_W'(r_total != TW'(TABLE_ENTRIES));
                            if (r_total != TW'(TABLE_ENTRIES))
                                r_total <= r_total + TW'(1);
                            r_state <= ST_OUT;
                        end else if (m_id == r_id) begin
                            r_odata <= OUT_W'(1);
                            r_state <= ST_OUT;
                        end else begin
                            r_idx <= r_idx + TW'(1);
                            r_ra  <= AW'(r_idx + TW'(1));
                            r_state <= ST_RD;
                        end
                    end else if (r_idx == r_total) begin
                        if (r_total == '0) begin
                            r_odata <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_RUN;
                        end
                    end else begin
                        r_dx <= ddx[POS_W] ? (POS_W+1)'(-ddx) : ddx;
                        r_dy <= ddy[POS_W] ? (POS_W+1)'(-ddy) : ddy;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_sq    <= sqx + sqy; // registered squares
                    r_state <= ST_MUL;
                end
                ST_MUL: r_state <= ST_DIV;
                ST_DIV: begin
                    // wait for the root, accumulate, flag a near neighbor and advance to the next entry
                    if (sq_done) begin
                        r_sum <= r_sum + SUM_W'(root);
                        if (root < DIST_W'(r_risk)) r_flag <= 1'b1;
                        r_idx <= r_idx + TW'(1);
                        r_ra  <= AW'(r_idx + TW'(1));
                        r_state <= ST_RD;
                    end
                end
                ST_RUN: begin
                    // hold until the mean is ready, then pack the report
                    if (dv_done) begin
                        r_odata <= OUT_W'({r_flag, quo[DIST_W-1:0], CNT_W'(r_total), 1'b0});
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_ouser <= (r_cmd == CMD_TICK) ? KIND_TICK : KIND_ACK;
                    r_ov    <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `NPM_ASSERT_IMP(a_fill, i_clk, i_rst_n, 1'b1, r_total <= TW'(TABLE_ENTRIES),
        "fill count past table size")
    `NPM_ASSERT_IMP(a_busy, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready,
        "request taken while busy")
    `NPM_ASSERT_NEXT(a_out, i_clk, i_rst_n, r_state == ST_OUT, r_ov,
        "result not posted")
endmodule
